// ----- rtl/fpseq_pkg.sv -----
// ----------------------------------------------------------------------------
// fpseq_pkg
// Shared types and constants of the frame playback sequencer.
// ----------------------------------------------------------------------------
package fpseq_pkg;

  localparam int unsigned MAX_FRAMES = 65536;
  localparam int unsigned MAX_SKIP   = 64;

  localparam int unsigned FRAME_W   = 16;  // current frame
  localparam int unsigned NFR_W     = 17;  // frame count register
  localparam int unsigned SKIP_W    = 7;   // frame skip register and step counter
  localparam int unsigned DELAY_W   = 16;
  localparam int unsigned ELAPSED_W = 17;
  localparam int unsigned STYLE_W   = 2;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned DIR_W     = 3;
  localparam int unsigned JUMP_W    = 17;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 17;

  // jump target code for the last frame; every other negative target means the first
  localparam logic signed [JUMP_W-1:0] JUMP_LAST = -17'sd2;

  typedef enum logic [DIR_W-1:0] {
    DIR_FORWARD = 3'd0,
    DIR_NEXT    = 3'd1,
    DIR_REVERSE = 3'd2,
    DIR_PREV    = 3'd3,
    DIR_PAUSE   = 3'd4
  } dir_e;

  typedef enum logic [STYLE_W-1:0] {
    STYLE_ONCE = 2'd0,
    STYLE_LOOP = 2'd1,
    STYLE_ROCK = 2'd2
  } style_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK = 2'd0,
    KIND_DIR  = 2'd1,
    KIND_JUMP = 2'd2
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_FRAMES  = 2'd0,
    CFG_FRAME_SKIP  = 2'd1,
    CFG_DELAY_TICKS = 2'd2,
    CFG_PLAY_STYLE  = 2'd3
  } cfg_idx_e;

  // playback position handed to and from the step unit
  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    dir_e               dir;
  } play_pos_t;

endpackage

// ----- rtl/fpseq_if.sv -----
// ----------------------------------------------------------------------------
// fpseq interfaces
// Request and result channels of the frame playback sequencer.
// ----------------------------------------------------------------------------
interface fpseq_in_if import fpseq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic [DIR_W-1:0]         new_direction;
  logic signed [JUMP_W-1:0] jump_frame;

  modport source (output valid, kind, new_direction, jump_frame, input ready);
  modport sink   (input valid, kind, new_direction, jump_frame, output ready);
endinterface

interface fpseq_out_if import fpseq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FRAME_W-1:0] frame_index;
  logic               frame_changed;
  logic [DIR_W-1:0]   direction_now;

  modport source (output valid, frame_index, frame_changed, direction_now, input ready);
  modport sink   (input valid, frame_index, frame_changed, direction_now, output ready);
endinterface

// ----- rtl/frame_playback_sequencer.sv -----
// ----------------------------------------------------------------------------
// frame_playback_sequencer
// Steps an animation frame index from tick, direction and jump requests.
// ----------------------------------------------------------------------------
// One result per request. A request is taken in S_IDLE and its result is
// written to the output register in S_PUSH once that register is free;
// direction, jump and non-firing tick requests go straight to S_PUSH. A
// firing tick first stays in S_STEP for frame_skip steps (taken as 1 when
// zero and at most 64), since a single step unit moves the frame by one
// position per cycle. A new request is taken as soon as the previous result
// sits in the output register, whether or not it has been collected yet.
module frame_playback_sequencer
  import fpseq_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  fpseq_in_if.sink              in_i,
  fpseq_out_if.source           out_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_STEP,
    S_PUSH
  } state_e;

  state_e              state_q, state_d;
  logic [NFR_W-1:0]    num_frames_q;
  logic [SKIP_W-1:0]   frame_skip_q;
  logic [DELAY_W-1:0]  delay_q;
  logic [STYLE_W-1:0]  style_q;

  play_pos_t           pos_q, pos_d;
  logic [ELAPSED_W-1:0] elapsed_q, elapsed_d;
  logic [SKIP_W-1:0]   steps_q, steps_d;
  logic                changed_q, changed_d;

  logic                out_valid_q, out_valid_d;
  logic [FRAME_W-1:0]  out_frame_q, out_frame_d;
  logic                out_changed_q, out_changed_d;
  logic [DIR_W-1:0]    out_dir_q, out_dir_d;

  logic [NFR_W-1:0]    used_n;
  logic [FRAME_W-1:0]  last_frame;
  logic [SKIP_W-1:0]   skip_eff;
  logic [ELAPSED_W-1:0] elapsed_inc;
  logic [FRAME_W-1:0]  jump_target;
  play_pos_t           step_pos;

  assign used_n = (num_frames_q > NFR_W'(MAX_FRAMES)) ? NFR_W'(MAX_FRAMES) : num_frames_q;
  assign last_frame = (used_n == '0) ? '0 : FRAME_W'(used_n - 1'b1);

  assign skip_eff = (frame_skip_q == '0) ? SKIP_W'(1) :
                    (frame_skip_q > SKIP_W'(MAX_SKIP)) ? SKIP_W'(MAX_SKIP) : frame_skip_q;

  assign elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + 1'b1;

  // first frame for every negative target but the last-frame code
  always_comb begin
    if (in_i.jump_frame == JUMP_LAST) begin
      jump_target = last_frame;
    end else if (in_i.jump_frame[JUMP_W-1]) begin
      jump_target = '0;
    end else if (in_i.jump_frame[FRAME_W-1:0] > last_frame) begin
      jump_target = last_frame;
    end else begin
      jump_target = in_i.jump_frame[FRAME_W-1:0];
    end
  end

  fpseq_step_unit u_step (
    .pos_i   (pos_q),
    .last_i  (last_frame),
    .style_i (style_q),
    .pos_o   (step_pos)
  );

  assign in_i.ready          = (state_q == S_IDLE);
  assign out_o.valid         = out_valid_q;
  assign out_o.frame_index   = out_frame_q;
  assign out_o.frame_changed = out_changed_q;
  assign out_o.direction_now = out_dir_q;

  always_comb begin
    state_d       = state_q;
    pos_d         = pos_q;
    elapsed_d     = elapsed_q;
    steps_d       = steps_q;
    changed_d     = changed_q;
    out_valid_d   = out_valid_q;
    out_frame_d   = out_frame_q;
    out_changed_d = out_changed_q;
    out_dir_d     = out_dir_q;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          state_d   = S_PUSH;
          changed_d = 1'b0;
          case (kind_e'(in_i.kind))
            KIND_TICK: begin
              elapsed_d = elapsed_inc;
              if (pos_q.dir != DIR_PAUSE && elapsed_inc > ELAPSED_W'(delay_q)) begin
                elapsed_d = '0;
                if (used_n >= NFR_W'(2)) begin
                  changed_d = 1'b1;
                  steps_d   = skip_eff;
                  state_d   = S_STEP;
                end
              end
            end
            KIND_DIR: begin
              if (in_i.new_direction <= DIR_PAUSE) begin
                pos_d.dir = dir_e'(in_i.new_direction);
              end
            end
            KIND_JUMP: pos_d.frame = jump_target;
            default: pos_d = pos_q;
          endcase
        end
      end
      S_STEP: begin
        pos_d   = step_pos;
        steps_d = steps_q - 1'b1;
        if (steps_q == SKIP_W'(1)) begin
          state_d = S_PUSH;
          // single-step directions stop after one firing, unless rock style turned them at an end
          if (step_pos.dir == DIR_NEXT || step_pos.dir == DIR_PREV) begin
            pos_d.dir = DIR_PAUSE;
          end
        end
      end
      S_PUSH: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d   = 1'b1;
          out_frame_d   = pos_q.frame;
          out_changed_d = changed_q;
          out_dir_d     = pos_q.dir;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      pos_q.frame   <= '0;
      pos_q.dir     <= DIR_PAUSE;
      elapsed_q     <= '0;
      steps_q       <= '0;
      changed_q     <= 1'b0;
      out_valid_q   <= 1'b0;
      out_frame_q   <= '0;
      out_changed_q <= 1'b0;
      out_dir_q     <= '0;
    end else begin
      state_q       <= state_d;
      pos_q         <= pos_d;
      elapsed_q     <= elapsed_d;
      steps_q       <= steps_d;
      changed_q     <= changed_d;
      out_valid_q   <= out_valid_d;
      out_frame_q   <= out_frame_d;
      out_changed_q <= out_changed_d;
      out_dir_q     <= out_dir_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_frames_q <= '0;
      frame_skip_q <= SKIP_W'(1);
      delay_q      <= '0;
      style_q      <= STYLE_LOOP;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_NUM_FRAMES:  num_frames_q <= cfg_data_i[NFR_W-1:0];
        CFG_FRAME_SKIP:  frame_skip_q <= cfg_data_i[SKIP_W-1:0];
        CFG_DELAY_TICKS: delay_q      <= cfg_data_i[DELAY_W-1:0];
        CFG_PLAY_STYLE:  style_q      <= cfg_data_i[STYLE_W-1:0];
        default:         style_q      <= style_q;
      endcase
    end
  end

endmodule

// ----- rtl/fpseq_step_unit.sv -----
// ----------------------------------------------------------------------------
// fpseq_step_unit
// One single-frame step: move forward or back, and handle the ends by style.
// ----------------------------------------------------------------------------
module fpseq_step_unit
  import fpseq_pkg::*;
(
  input  play_pos_t          pos_i,
  input  logic [FRAME_W-1:0] last_i,
  input  logic [STYLE_W-1:0] style_i,
  output play_pos_t          pos_o
);

  always_comb begin
    pos_o = pos_i;
    case (pos_i.dir)
      DIR_REVERSE, DIR_PREV: begin
        if (pos_i.frame == '0) begin
          case (style_e'(style_i))
            STYLE_LOOP: pos_o.frame = last_i;
            STYLE_ROCK: pos_o.dir   = DIR_FORWARD;
            STYLE_ONCE: pos_o.dir   = DIR_PAUSE;
            default:    pos_o = pos_i;
          endcase
        end else begin
          pos_o.frame = pos_i.frame - 1'b1;
        end
      end
      DIR_FORWARD, DIR_NEXT: begin
        // a frame beyond the count counts as the end
        if (pos_i.frame >= last_i) begin
          case (style_e'(style_i))
            STYLE_LOOP: pos_o.frame = '0;
            STYLE_ROCK: pos_o.dir   = DIR_REVERSE;
            STYLE_ONCE: pos_o.dir   = DIR_PAUSE;
            default:    pos_o = pos_i;
          endcase
        end else begin
          pos_o.frame = pos_i.frame + 1'b1;
        end
      end
      default: pos_o = pos_i;
    endcase
  end

endmodule
